[hw/rtl/dcm_pkg.sv]
// Shared types and constants for the direction-cosine-matrix to Euler angle block.
// Holds the transaction payload structs, the pipeline data structs and the arctangent table.
// No dependencies.
`default_nettype none

package dcm_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = SAMPLE_BITS - 1;
    localparam int OPW          = SAMPLE_BITS + 1;
    localparam int NW           = 2 * SAMPLE_BITS;
    localparam int XW           = 44;
    localparam int ZW           = 34;
    localparam int CORDIC_STEPS = 32;
    localparam int WORK_SHIFT   = 40 - FRAC_BITS;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] r0c0;
        logic signed [SAMPLE_BITS-1:0] r0c1;
        logic signed [SAMPLE_BITS-1:0] r0c2;
        logic signed [SAMPLE_BITS-1:0] r1c1;
        logic signed [SAMPLE_BITS-1:0] r1c2;
        logic signed [SAMPLE_BITS-1:0] r2c1;
        logic signed [SAMPLE_BITS-1:0] r2c2;
    } in_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] heading_angle;
        logic                         gimbal_lock;
    } out_t;

    typedef struct packed {
        logic signed [OPW-1:0] s;
        logic signed [OPW-1:0] ry;
        logic signed [OPW-1:0] rx;
        logic signed [OPW-1:0] hy;
        logic signed [OPW-1:0] hx;
        logic                  lock;
    } pre_t;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [NW-1:0] r;
        pre_t          side;
    } sqrt_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
        logic                 tag;
    } cordic_t;

endpackage

`default_nettype wire

[hw/rtl/dcm_sqrt_cell.sv]
// One stage of the pipelined integer square root: resolves one result bit.
// Depends on dcm_pkg.
`default_nettype none

module dcm_sqrt_cell #(
    parameter int K = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire dcm_pkg::sqrt_t in_data,
    output logic                out_valid,
    output dcm_pkg::sqrt_t      out_data
);
    import dcm_pkg::*;

    logic          valid_reg;
    sqrt_t         data_reg;
    sqrt_t         data_next;
    logic [NW-1:0] bit_val;
    logic [NW-1:0] trial;

    always_comb begin
        bit_val   = NW'(1) << (2 * K);
        trial     = in_data.r + bit_val;
        data_next = in_data;
        if (in_data.n >= trial) begin
            data_next.n = in_data.n - trial;
            data_next.r = (in_data.r >> 1) + bit_val;
        end else begin
            data_next.r = in_data.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/dcm_cordic_cell.sv]
// One CORDIC vectoring step with its arctangent constant.
// Depends on dcm_pkg.
`default_nettype none

module dcm_cordic_cell #(
    parameter int I = 0
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire dcm_pkg::cordic_t in_data,
    output logic                  out_valid,
    output dcm_pkg::cordic_t      out_data
);
    import dcm_pkg::*;

    logic                 valid_reg;
    cordic_t              data_reg;
    cordic_t              data_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] angle;

    always_comb begin
        dx        = in_data.y >>> I;
        dy        = in_data.x >>> I;
        angle     = $signed({{(ZW - 32){1'b0}}, ATAN_TAB[I]});
        data_next = in_data;
        if (!in_data.y[XW-1]) begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + angle;
        end else begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/dcm_cordic_lane.sv]
// Full atan2 lane: quadrant fold, a chain of CORDIC cells and output rounding.
// Depends on dcm_pkg and dcm_cordic_cell.
`default_nettype none

module dcm_cordic_lane (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire logic signed [dcm_pkg::OPW-1:0]        y_in,
    input  wire logic signed [dcm_pkg::OPW-1:0]        x_in,
    input  wire logic                                  tag_in,
    output logic                                       out_valid,
    output logic signed [dcm_pkg::ANGLE_BITS-1:0]      angle,
    output logic                                       tag_out
);
    import dcm_pkg::*;

    localparam int RSH = 32 - ANGLE_BITS;

    logic                         stage_valid [CORDIC_STEPS+1];
    cordic_t                      stage_data  [CORDIC_STEPS+1];
    logic                         prep_valid_reg;
    cordic_t                      prep_reg;
    cordic_t                      prep_next;
    logic signed [XW-1:0]         xs;
    logic signed [XW-1:0]         ys;
    logic signed [ZW-1:0]         z_round;
    logic                         valid_reg;
    logic signed [ANGLE_BITS-1:0] angle_reg;
    logic                         tag_reg;

    always_comb begin
        xs = $signed({{(XW - OPW){x_in[OPW-1]}}, x_in}) <<< WORK_SHIFT;
        ys = $signed({{(XW - OPW){y_in[OPW-1]}}, y_in}) <<< WORK_SHIFT;
        prep_next.x    = xs;
        prep_next.y    = ys;
        prep_next.z    = '0;
        prep_next.zero = (x_in == '0) && (y_in == '0);
        prep_next.tag  = tag_in;
        if (xs[XW-1]) begin
            if (!ys[XW-1]) begin
                prep_next.x = ys;
                prep_next.y = -xs;
                prep_next.z = ZW'(34'sh040000000);
            end else begin
                prep_next.x = -ys;
                prep_next.y = xs;
                prep_next.z = -ZW'(34'sh040000000);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign stage_valid[0] = prep_valid_reg;
    assign stage_data[0]  = prep_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        dcm_cordic_cell #(
            .I(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (stage_valid[i]),
            .in_data  (stage_data[i]),
            .out_valid(stage_valid[i+1]),
            .out_data (stage_data[i+1])
        );
    end

    if (RSH == 0) begin : g_no_round
        assign z_round = stage_data[CORDIC_STEPS].z;
    end else begin : g_round
        assign z_round = (stage_data[CORDIC_STEPS].z + (ZW'(1) <<< (RSH - 1))) >>> RSH;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= stage_data[CORDIC_STEPS].zero ? '0 : z_round[ANGLE_BITS-1:0];
            tag_reg   <= stage_data[CORDIC_STEPS].tag;
        end
    end

    assign out_valid = valid_reg;
    assign angle     = angle_reg;
    assign tag_out   = tag_reg;

endmodule

`default_nettype wire

[hw/rtl/dcm_to_euler_angles.sv]
// Pipeline from input transaction to result: input stage, 16 square-root cells, fold stage,
// 32 CORDIC cells, rounding stage, output register.
// Throughput: one transaction per cycle; the whole cell chain advances together and halts
// only when a finished result sits at the end of the chain and the output is held.
// Reset: synchronous active-low aresetn clears every valid bit; data registers are not reset.
// Top level of the matrix to roll, pitch and heading converter; depends on dcm_pkg,
// dcm_sqrt_cell and dcm_cordic_lane.
`default_nettype none

module dcm_to_euler_angles (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire dcm_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output dcm_pkg::out_t      m_data
);
    import dcm_pkg::*;

    localparam logic signed [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) <<< (ANGLE_BITS - 2);
    localparam logic [NW-1:0]                ONE_SQ  = NW'(1) << (2 * FRAC_BITS);

    logic                         en;
    logic                         norm;
    pre_t                         pre_next;
    logic signed [2*OPW-1:0]      s_sq;
    sqrt_t                        in_next;
    logic                         in_valid_reg;
    sqrt_t                        in_reg;
    logic                         sq_valid [SAMPLE_BITS+1];
    sqrt_t                        sq_data  [SAMPLE_BITS+1];
    logic                         pitch_valid;
    logic signed [ANGLE_BITS-1:0] pitch_raw;
    logic signed [ANGLE_BITS-1:0] roll_raw;
    logic signed [ANGLE_BITS-1:0] heading_raw;
    logic                         lock_out;
    logic signed [ANGLE_BITS-1:0] pitch_clamped;
    logic                         m_valid_reg;
    out_t                         m_data_reg;

    assign en      = !pitch_valid || !m_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        norm = ((s_data.r1c2 != '0) || (s_data.r2c2 != '0)) &&
               ((s_data.r0c1 != '0) || (s_data.r0c0 != '0));
        pre_next.s    = -OPW'(s_data.r0c2);
        pre_next.ry   = norm ? OPW'(s_data.r1c2) : -OPW'(s_data.r2c1);
        pre_next.rx   = norm ? OPW'(s_data.r2c2) : OPW'(s_data.r1c1);
        pre_next.hy   = norm ? OPW'(s_data.r0c1) : '0;
        pre_next.hx   = norm ? OPW'(s_data.r0c0) : '0;
        pre_next.lock = !norm;
        s_sq          = pre_next.s * pre_next.s;
        in_next.n     = ONE_SQ - s_sq[NW-1:0];
        in_next.r     = '0;
        in_next.side  = pre_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= in_next;
        end
    end

    assign sq_valid[0] = in_valid_reg;
    assign sq_data[0]  = in_reg;

    for (genvar k = 0; k < SAMPLE_BITS; k++) begin : g_sqrt
        dcm_sqrt_cell #(
            .K(FRAC_BITS - k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (sq_valid[k]),
            .in_data  (sq_data[k]),
            .out_valid(sq_valid[k+1]),
            .out_data (sq_data[k+1])
        );
    end

    dcm_cordic_lane u_pitch (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (sq_valid[SAMPLE_BITS]),
        .y_in     (sq_data[SAMPLE_BITS].side.s),
        .x_in     ($signed(sq_data[SAMPLE_BITS].r[OPW-1:0])),
        .tag_in   (1'b0),
        .out_valid(pitch_valid),
        .angle    (pitch_raw),
        .tag_out  ()
    );

    dcm_cordic_lane u_roll (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (sq_valid[SAMPLE_BITS]),
        .y_in     (sq_data[SAMPLE_BITS].side.ry),
        .x_in     (sq_data[SAMPLE_BITS].side.rx),
        .tag_in   (sq_data[SAMPLE_BITS].side.lock),
        .out_valid(),
        .angle    (roll_raw),
        .tag_out  (lock_out)
    );

    dcm_cordic_lane u_heading (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (sq_valid[SAMPLE_BITS]),
        .y_in     (sq_data[SAMPLE_BITS].side.hy),
        .x_in     (sq_data[SAMPLE_BITS].side.hx),
        .tag_in   (1'b0),
        .out_valid(),
        .angle    (heading_raw),
        .tag_out  ()
    );

    always_comb begin
        pitch_clamped = pitch_raw;
        if (pitch_raw > QUARTER) begin
            pitch_clamped = QUARTER;
        end else if (pitch_raw < -QUARTER) begin
            pitch_clamped = -QUARTER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= pitch_valid || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (en && pitch_valid) begin
            m_data_reg.roll_angle    <= roll_raw;
            m_data_reg.pitch_angle   <= pitch_clamped;
            m_data_reg.heading_angle <= heading_raw;
            m_data_reg.gimbal_lock   <= lock_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_lock_heading_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.gimbal_lock) |-> (m_data.heading_angle == '0))
        else $error("Gimbal lock transaction with nonzero heading.");

    a_pitch_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.pitch_angle <= QUARTER) && (m_data.pitch_angle >= -QUARTER)))
        else $error("Pitch outside half-pi bound.");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && pitch_valid))
        else $error("Input stalled without a held result.");
`endif

endmodule

`default_nettype wire
